// ----- hw/rtl/nde_pkg.sv -----
// Shared types, constants and the arctangent table for the direction expander.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nde_pkg;
    localparam int CORDIC_STEPS = 18;
    localparam int CFG_BITS     = 4;
    localparam int RESULT_CAP   = 8;
    localparam int IDX_BITS     = 3;
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032875;

    typedef logic [31:0] turn_t;

    function automatic turn_t atan_turn(input logic [4:0] i);
        turn_t r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // floor(2^32 * j / n), n in 1..8, j < n
    // j * ceil(2^38 / n) >> 6 is exact here: the rounding error stays below 2^6 / n
    function automatic turn_t copy_step(input logic [3:0] n, input logic [2:0] j);
        logic [38:0] m;
        logic [41:0] p;
        case (n)
            4'd1: m = 39'd274877906944;
            4'd2: m = 39'd137438953472;
            4'd3: m = 39'd91625968982;
            4'd4: m = 39'd68719476736;
            4'd5: m = 39'd54975581389;
            4'd6: m = 39'd45812984491;
            4'd7: m = 39'd39268272421;
            4'd8: m = 39'd34359738368;
            default: m = 39'd0;
        endcase
        p = 42'(j) * 42'(m);
        return p[37:6];
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/nde_if.sv -----
// Valid/ready stream interface carrying a packed payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface nde_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/nrosy_direction_expander_top.sv -----
// N-RoSy direction expander: top level, ties front end, queue and back end.
// Depends on nde_pkg, nde_if, nde_front, nde_queue, nde_back.
//
// Usage:
//   in  : one beat per face = {basis2 zyx, basis1 zyx, rep zyx}, COORD_BITS each.
//   out : 1..8 beats per face (degree, clamped) = {last, copy_index, dir_z, dir_y, dir_x}.
//   degree register written via cfg_we / cfg_data while idle; reset value 4.
// Path: a face passes through the front (products, normalise, 18-step vectoring
//   CORDIC), the registered queue and the back (rotation CORDIC, recombine
//   multiply, saturation); the first direction of a face is held back while the
//   back is still busy with earlier faces.
// Throughput: one output beat per cycle while out_ch.ready is high and faces are
//   queued; the back-end rotation pipeline issuing one copy per cycle sets this.
// Reset clears all valid flags and the copy counter, degree returns to 4.
// A stall on the output freezes the back pipeline; the front accepts faces
//   until the queue is full and its last stage holds a face, then drops in_ch.ready.
`timescale 1ns / 1ps
`default_nettype none
module nrosy_direction_expander_top #(
    parameter int MAX_DEGREE = 8,
    parameter int COORD_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [nde_pkg::CFG_BITS-1:0] cfg_data,
    nde_if.sink   in_ch,
    nde_if.source out_ch
);
    import nde_pkg::*;
    localparam int QW = 6*COORD_BITS + 32;

    logic [CFG_BITS-1:0] degree_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            degree_reg <= 4'd4;
        else if (cfg_we)
            degree_reg <= cfg_data;
    end

    logic f_v, f_r, b_v, b_r;
    logic [QW-1:0] f_d, b_d;

    nde_front #(.CB(COORD_BITS)) u_front (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(f_v), .out_ready(f_r), .out_data(f_d)
    );

    nde_queue #(.W(QW)) u_queue (
        .clk, .rst_n,
        .in_valid(f_v), .in_ready(f_r), .in_data(f_d),
        .out_valid(b_v), .out_ready(b_r), .out_data(b_d)
    );

    nde_back #(.CB(COORD_BITS), .MAX_DEGREE(MAX_DEGREE)) u_back (
        .clk, .rst_n, .degree(degree_reg),
        .in_valid(b_v), .in_ready(b_r), .in_data(b_d),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
    );

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output beat changed under stall");
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data[3*COORD_BITS+3] && degree_reg <= 4'd8
        && degree_reg != 4'd0 |-> out_ch.data[3*COORD_BITS +: 3] == 3'(degree_reg - 4'd1))
        else $error("last flag on wrong copy");
endmodule
`default_nettype wire

// ----- hw/rtl/nde_front.sv -----
// Front end: projections, normalisation and vectoring CORDIC giving the face angle.
// Depends on nde_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nde_front #(
    parameter int CB = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [9*CB-1:0]      in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [6*CB+32-1:0]        out_data
);
    import nde_pkg::*;
    localparam int PS = (CB > 30) ? 2 : 0;
    localparam int PW = 2*CB + 2;          // dot-product width
    localparam int CW = 34;                // cordic working width
    localparam int NS = 2 + CORDIC_STEPS + 1; // stage count
    localparam logic signed [CW-1:0] NEG_TOP = CW'(-64'sd536870912);

    // pipeline: stage 0 products, stage 1 normalise, stages 2..NS-2 cordic, last stage zero-input fix
    logic              v_reg [NS];
    logic [6*CB-1:0]   b_reg [NS];
    logic signed [CW-1:0] x_reg [NS];
    logic signed [CW-1:0] y_reg [NS];
    turn_t             z_reg [NS];
    logic signed [PW-1:0] px_reg, py_reg;
    logic              zero_reg [NS];
    logic              adv;

    assign adv      = !v_reg[NS-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[NS-1];
    assign out_data = {b_reg[NS-1], z_reg[NS-1]};

    logic signed [CB-1:0] f [9];
    logic signed [PW-1:0] px_c, py_c;
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            f[k] = in_data[k*CB +: CB];
        px_c = ((PW'(f[0]) * PW'(f[3])) >>> PS) + ((PW'(f[1]) * PW'(f[4])) >>> PS)
             + ((PW'(f[2]) * PW'(f[5])) >>> PS);
        py_c = ((PW'(f[0]) * PW'(f[6])) >>> PS) + ((PW'(f[1]) * PW'(f[7])) >>> PS)
             + ((PW'(f[2]) * PW'(f[8])) >>> PS);
    end

    // normalise into [2^28, 2^29): leading-bit shift on the larger magnitude
    logic [PW-1:0] ax, ay, m;
    logic signed [CW-1:0] nx, ny;
    int lead;
    always_comb
    begin
        ax = px_reg[PW-1] ? PW'(-px_reg) : PW'(px_reg);
        ay = py_reg[PW-1] ? PW'(-py_reg) : PW'(py_reg);
        m  = (ax > ay) ? ax : ay;
        lead = 0;
        for (int b = 0; b < PW; b++)
            if (m[b]) lead = b;
        if (lead >= 28)
        begin
            nx = CW'(64'(signed'(px_reg)) >>> (lead - 28));
            ny = CW'(64'(signed'(py_reg)) >>> (lead - 28));
        end
        else
        begin
            nx = CW'(64'(signed'(px_reg)) <<< (28 - lead));
            ny = CW'(64'(signed'(py_reg)) <<< (28 - lead));
        end
        // a negative value can floor onto -2^29, which needs one more halving
        if (nx == NEG_TOP || ny == NEG_TOP)
        begin
            nx = nx >>> 1;
            ny = ny >>> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg[0]  <= in_data[9*CB-1:3*CB];
            px_reg    <= px_c;
            py_reg    <= py_c;
            // stage 1: normalise and fold the left half-plane
            b_reg[1]    <= b_reg[0];
            zero_reg[1] <= (px_reg == '0) && (py_reg == '0);
            x_reg[1]    <= nx[CW-1] ? -nx : nx;
            y_reg[1]    <= nx[CW-1] ? -ny : ny;
            z_reg[1]    <= nx[CW-1] ? 32'h80000000 : 32'h0;
            for (int s = 2; s < NS; s++)
            begin
                b_reg[s]    <= b_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                if (s == NS-1)
                begin
                    x_reg[s] <= x_reg[s-1];
                    y_reg[s] <= y_reg[s-1];
                    z_reg[s] <= zero_reg[s-1] ? 32'h0 : z_reg[s-1];
                end
                else if (!y_reg[s-1][CW-1])
                begin
                    x_reg[s] <= x_reg[s-1] + (y_reg[s-1] >>> (s-2));
                    y_reg[s] <= y_reg[s-1] - (x_reg[s-1] >>> (s-2));
                    z_reg[s] <= z_reg[s-1] + atan_turn(5'(s-2));
                end
                else
                begin
                    x_reg[s] <= x_reg[s-1] - (y_reg[s-1] >>> (s-2));
                    y_reg[s] <= y_reg[s-1] + (x_reg[s-1] >>> (s-2));
                    z_reg[s] <= z_reg[s-1] - atan_turn(5'(s-2));
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/nde_queue.sv -----
// Short two-entry FIFO between front and back ends.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module nde_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= in_data;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/nde_back.sv -----
// Back end: sequences the N copies through a pipelined rotation CORDIC and
// recombines them in 3D with saturation. Depends on nde_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nde_back #(
    parameter int CB = 16,
    parameter int MAX_DEGREE = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [nde_pkg::CFG_BITS-1:0] degree,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [6*CB+32-1:0]     in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [3*CB+nde_pkg::IDX_BITS:0] out_data
);
    import nde_pkg::*;
    localparam int CW = 34;
    localparam int NS = 1 + CORDIC_STEPS + 2; // issue, cordic, mult, sat
    localparam int LIM = (MAX_DEGREE < RESULT_CAP) ? MAX_DEGREE : RESULT_CAP;

    logic                 v_reg   [NS];
    logic [6*CB-1:0]      b_reg   [NS];
    logic [IDX_BITS-1:0]  i_reg   [NS];
    logic                 l_reg   [NS];
    logic                 neg_reg [NS];
    logic signed [CW-1:0] x_reg   [NS];
    logic signed [CW-1:0] y_reg   [NS];
    logic signed [CW-1:0] a_reg   [NS];
    logic signed [CW+CB:0] pr_reg [3];
    logic signed [CB-1:0] o_reg   [3];

    function automatic logic signed [CB-1:0] sat(input logic signed [CW+CB:0] p);
        logic signed [CW+CB:0] v;
        v = (p + (CW+CB+1)'(64'sd1 << 29)) >>> 30;
        if (v > (CW+CB+1)'((64'sd1 <<< (CB-1)) - 1))
            return {1'b0, {(CB-1){1'b1}}};
        else if (v < -(CW+CB+1)'(64'sd1 <<< (CB-1)))
            return {1'b1, {(CB-1){1'b0}}};
        return CB'(v);
    endfunction

    logic [3:0] n;
    always_comb
    begin
        n = degree;
        if (n == 4'd0) n = 4'd1;
        if (n > 4'(LIM)) n = 4'(LIM);
    end

    logic [IDX_BITS-1:0] j_reg;
    logic adv, issue, lastc;
    assign lastc  = (4'(j_reg) == n - 4'd1);
    assign adv    = !v_reg[NS-1] || out_ready;
    assign issue  = adv && in_valid;
    assign in_ready = adv && lastc;

    turn_t ang;
    logic signed [CW-1:0] a0;
    always_comb
    begin
        ang = in_data[31:0] + copy_step(n, j_reg);
        a0  = CW'(signed'(ang));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg <= '0;
            for (int s = 0; s < NS; s++)
                v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            if (issue)
                j_reg <= lastc ? '0 : j_reg + 1'b1;
            v_reg[0] <= issue;
            for (int s = 1; s < NS; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    localparam logic signed [CW-1:0] QT = CW'(64'sd1 << 30);
    localparam logic signed [CW-1:0] HT = CW'(64'sd1 << 31);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg[0] <= in_data[6*CB+31:32];
            i_reg[0] <= j_reg;
            l_reg[0] <= lastc;
            x_reg[0] <= CW'(INV_GAIN_Q30);
            y_reg[0] <= '0;
            if (a0 > QT)
            begin
                a_reg[0] <= a0 - HT; neg_reg[0] <= 1'b1;
            end
            else if (a0 < -QT)
            begin
                a_reg[0] <= a0 + HT; neg_reg[0] <= 1'b1;
            end
            else
            begin
                a_reg[0] <= a0; neg_reg[0] <= 1'b0;
            end
            for (int s = 1; s < NS; s++)
            begin
                b_reg[s] <= b_reg[s-1];
                i_reg[s] <= i_reg[s-1];
                l_reg[s] <= l_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            for (int s = 1; s <= CORDIC_STEPS; s++)
            begin
                if (!a_reg[s-1][CW-1])
                begin
                    x_reg[s] <= x_reg[s-1] - (y_reg[s-1] >>> (s-1));
                    y_reg[s] <= y_reg[s-1] + (x_reg[s-1] >>> (s-1));
                    a_reg[s] <= a_reg[s-1] - CW'(atan_turn(5'(s-1)));
                end
                else
                begin
                    x_reg[s] <= x_reg[s-1] + (y_reg[s-1] >>> (s-1));
                    y_reg[s] <= y_reg[s-1] - (x_reg[s-1] >>> (s-1));
                    a_reg[s] <= a_reg[s-1] + CW'(atan_turn(5'(s-1)));
                end
            end
            // products (negation folded into sign of sum)
            for (int k = 0; k < 3; k++)
                pr_reg[k] <= (CW+CB+1)'(x_reg[CORDIC_STEPS])
                           * (CW+CB+1)'(signed'(b_reg[CORDIC_STEPS][k*CB +: CB]))
                           + (CW+CB+1)'(y_reg[CORDIC_STEPS])
                           * (CW+CB+1)'(signed'(b_reg[CORDIC_STEPS][(3+k)*CB +: CB]));
            for (int k = 0; k < 3; k++)
                o_reg[k] <= sat(neg_reg[NS-2] ? -pr_reg[k] : pr_reg[k]);
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_data  = {l_reg[NS-1], i_reg[NS-1], o_reg[2], o_reg[1], o_reg[0]};
endmodule
`default_nettype wire
